>>> rtl/hbwd_pkg.sv
// Shared types and codes for the heartbeat watchdog.
package hbwd_pkg;

  localparam logic [1:0] FUNC_REGISTER  = 2'd0;
  localparam logic [1:0] FUNC_HEARTBEAT = 2'd1;
  localparam logic [1:0] FUNC_TICK      = 2'd2;
  localparam logic [1:0] FUNC_QUERY     = 2'd3;

  localparam logic [1:0] ST_OFFLINE = 2'd0;
  localparam logic [1:0] ST_ONLINE  = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;

  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  localparam logic [31:0] DEFAULT_TIMEOUT_RST = 32'd3000;

  // one slot entry as held in the slot memory
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] last_hb;
    logic [31:0] timeout;
  } entry_t;

  // one result item
  typedef struct packed {
    logic        kind;
    logic [3:0]  slot;
    logic [1:0]  status;
    logic [31:0] last_seen;
    logic [31:0] limit_ms;
    logic        last;
  } res_t;

endpackage

>>> rtl/hbwd_if.sv
// Valid/ready channel interfaces for commands and results.
interface hbwd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [3:0]  service;
  logic [31:0] timestamp;
  logic [31:0] timeout_ms;

  modport source (output valid, output func, output service, output timestamp,
                  output timeout_ms, input ready);
  modport sink   (input valid, input func, input service, input timestamp,
                  input timeout_ms, output ready);
endinterface

interface hbwd_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [3:0]  slot;
  logic [1:0]  status;
  logic [31:0] last_seen;
  logic [31:0] limit_ms;
  logic        last;

  modport source (output valid, output kind, output slot, output status,
                  output last_seen, output limit_ms, output last, input ready);
  modport sink   (input valid, input kind, input slot, input status,
                  input last_seen, input limit_ms, input last, output ready);
endinterface

>>> rtl/hbwd_slot_mem.sv
// Slot table memory: one write port, one read port with registered data.
module hbwd_slot_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [AW-1:0]          wr_addr,
  input  hbwd_pkg::entry_t       wr_data,
  input  logic                   rd_en,
  input  logic [AW-1:0]          rd_addr,
  output hbwd_pkg::entry_t       rd_data
);

  hbwd_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/hbwd_out_stage.sv
// Output register between the sequencer and the result channel.
module hbwd_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  hbwd_pkg::res_t     res,
  output logic               free,
  hbwd_out_if.source         out_ch
);

  logic           vld_r;
  hbwd_pkg::res_t res_r;

  assign free = !vld_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (push) begin
      vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      res_r <= res;
    end
  end

  assign out_ch.valid     = vld_r;
  assign out_ch.kind      = res_r.kind;
  assign out_ch.slot      = res_r.slot;
  assign out_ch.status    = res_r.status;
  assign out_ch.last_seen = res_r.last_seen;
  assign out_ch.limit_ms  = res_r.limit_ms;
  assign out_ch.last      = res_r.last;

endmodule

>>> rtl/hbwd_seq.sv
// Command sequencer: read-modify-write of slot entries and the tick scan.
module hbwd_seq #(
  parameter int SLOTS = 16,
  parameter int IDX_W = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  hbwd_in_if.sink            in_ch,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_wdata,
  output logic               rd_en,
  output logic [IDX_W-1:0]   rd_addr,
  input  hbwd_pkg::entry_t   rd_data,
  output logic               wr_en,
  output logic [IDX_W-1:0]   wr_addr,
  output hbwd_pkg::entry_t   wr_data,
  output logic               push,
  output hbwd_pkg::res_t     res,
  input  logic               out_free
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_TRD  = 5'b00100,
    S_TEX  = 5'b01000,
    S_TFIN = 5'b10000
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  state_t             state_r, state_nxt;
  logic [1:0]         func_r;
  logic [3:0]         svc_r;
  logic [31:0]        ts_r, tmo_r;
  logic [31:0]        dflt_r;
  logic [IDX_W-1:0]   scan_r, scan_nxt;
  logic               pend_vld_r, pend_vld_nxt;
  logic [IDX_W-1:0]   pend_slot_r, pend_slot_nxt;
  logic [SLOTS-1:0]   reg_vld_r, reg_vld_nxt;

  logic               accept;
  logic [IDX_W-1:0]   svc_idx;
  logic               svc_ok;
  logic               svc_reg;
  hbwd_pkg::entry_t   cur;
  logic               hit;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign svc_idx     = IDX_W'(svc_r);
  assign svc_ok      = (32'(svc_r) < SLOTS);
  assign svc_reg     = svc_ok && reg_vld_r[svc_idx];

  // an entry that was never registered reads as offline with a last heartbeat of zero
  always_comb begin
    cur = rd_data;
    if (!svc_reg) begin
      cur.status  = hbwd_pkg::ST_OFFLINE;
      cur.last_hb = 32'd0;
    end
  end

  assign hit = reg_vld_r[scan_r] && (rd_data.status == hbwd_pkg::ST_ONLINE) &&
               ((ts_r - rd_data.last_hb) > rd_data.timeout);

  always_comb begin
    state_nxt     = state_r;
    scan_nxt      = scan_r;
    pend_vld_nxt  = pend_vld_r;
    pend_slot_nxt = pend_slot_r;
    reg_vld_nxt   = reg_vld_r;
    rd_en         = 1'b0;
    rd_addr       = scan_r;
    wr_en         = 1'b0;
    wr_addr       = svc_idx;
    wr_data       = cur;
    push          = 1'b0;
    res           = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_ch.func == hbwd_pkg::FUNC_TICK) begin
            scan_nxt     = '0;
            pend_vld_nxt = 1'b0;
            state_nxt    = S_TRD;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = IDX_W'(in_ch.service);
            state_nxt = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        case (func_r)
          hbwd_pkg::FUNC_REGISTER: begin
            if (svc_ok) begin
              wr_en                = 1'b1;
              wr_data.status       = hbwd_pkg::ST_OFFLINE;
              wr_data.timeout      = (tmo_r != 32'd0) ? tmo_r : dflt_r;
              reg_vld_nxt[svc_idx] = 1'b1;
            end
            state_nxt = S_IDLE;
          end
          hbwd_pkg::FUNC_HEARTBEAT: begin
            if (!svc_reg) begin
              state_nxt = S_IDLE;
            end else if (cur.status == hbwd_pkg::ST_ONLINE) begin
              wr_en           = 1'b1;
              wr_data.last_hb = ts_r;
              state_nxt       = S_IDLE;
            end else if (out_free) begin
              wr_en           = 1'b1;
              wr_data.status  = hbwd_pkg::ST_ONLINE;
              wr_data.last_hb = ts_r;
              push            = 1'b1;
              res = '{kind: hbwd_pkg::KIND_REPORT, slot: svc_r,
                      status: hbwd_pkg::ST_ONLINE, last_seen: ts_r,
                      limit_ms: cur.timeout, last: 1'b1};
              state_nxt       = S_IDLE;
            end
          end
          hbwd_pkg::FUNC_QUERY: begin
            if (out_free) begin
              push = 1'b1;
              if (svc_reg) begin
                res = '{kind: hbwd_pkg::KIND_QUERY, slot: svc_r, status: cur.status,
                        last_seen: cur.last_hb, limit_ms: cur.timeout, last: 1'b1};
              end else begin
                res = '{kind: hbwd_pkg::KIND_QUERY, slot: svc_r,
                        status: hbwd_pkg::ST_OFFLINE, last_seen: 32'd0,
                        limit_ms: dflt_r, last: 1'b1};
              end
              state_nxt = S_IDLE;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_TRD: begin
        rd_en     = 1'b1;
        rd_addr   = scan_r;
        state_nxt = S_TEX;
      end
      S_TEX: begin
        // a hit is held pending until the next hit or the end of the scan so the final report can carry last
        if (!(hit && pend_vld_r && !out_free)) begin
          if (hit) begin
            wr_en          = 1'b1;
            wr_addr        = scan_r;
            wr_data        = rd_data;
            wr_data.status = hbwd_pkg::ST_TIMEOUT;
            if (pend_vld_r) begin
              push = 1'b1;
              res  = '{kind: hbwd_pkg::KIND_REPORT, slot: 4'(pend_slot_r),
                       status: hbwd_pkg::ST_TIMEOUT, last_seen: 32'd0,
                       limit_ms: dflt_r, last: 1'b0};
            end
            pend_vld_nxt  = 1'b1;
            pend_slot_nxt = scan_r;
          end
          if (scan_r == LAST_IDX) begin
            state_nxt = S_TFIN;
          end else begin
            scan_nxt  = scan_r + 1'b1;
            state_nxt = S_TRD;
          end
        end
      end
      S_TFIN: begin
        if (!pend_vld_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          push         = 1'b1;
          res          = '{kind: hbwd_pkg::KIND_REPORT, slot: 4'(pend_slot_r),
                           status: hbwd_pkg::ST_TIMEOUT, last_seen: 32'd0,
                           limit_ms: dflt_r, last: 1'b1};
          pend_vld_nxt = 1'b0;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      scan_r      <= '0;
      pend_vld_r  <= 1'b0;
      pend_slot_r <= '0;
      reg_vld_r   <= '0;
      dflt_r      <= hbwd_pkg::DEFAULT_TIMEOUT_RST;
    end else begin
      state_r     <= state_nxt;
      scan_r      <= scan_nxt;
      pend_vld_r  <= pend_vld_nxt;
      pend_slot_r <= pend_slot_nxt;
      reg_vld_r   <= reg_vld_nxt;
      if (cfg_we) begin
        dflt_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_ch.func;
      svc_r  <= in_ch.service;
      ts_r   <= in_ch.timestamp;
      tmo_r  <= in_ch.timeout_ms;
    end
  end

  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> out_free)
    else $error("result pushed into a full output register");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && rd_en))
    else $error("slot read and write in the same cycle");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_vld_r)
    else $error("timeout report left pending after scan");

  a_scan_write: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && state_r == S_TEX) |-> (wr_data.status == hbwd_pkg::ST_TIMEOUT))
    else $error("scan wrote a status other than timed out");

endmodule

>>> rtl/multi_channel_heartbeat_watchdog_core.sv
// Top level of the multi-channel heartbeat watchdog.
// Commands arrive on in_ch (register, heartbeat, tick, query) and results
// leave on out_ch; both are valid/ready channels, a transaction moving at a
// clock edge with valid and ready high. cfg_we/cfg_wdata set the default
// timeout; it is to be written only while the block is idle, which the
// block itself does not enforce. Slot state lives in a single-port-read,
// single-port-write memory; register, heartbeat and query read their slot
// in IDLE; in EXEC register and heartbeat write the entry back, and query
// and a heartbeat that brings a slot online push a result into the output
// register. A new command is taken only in IDLE. A tick walks all slots,
// reading each in TRD and checking it in TEX, then closes in TFIN; timeout
// reports stream out while it walks.
// Reset clears the per-slot registered bits at once (no clearing pass) and
// loads the default timeout of 3000 ms.
// A stalled receiver holds the output register; the sequencer waits with
// its pending result until the register frees, and takes no new command.
module multi_channel_heartbeat_watchdog_core #(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  hbwd_in_if.sink     in_ch,
  hbwd_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic               rd_en, wr_en, push, out_free;
  logic [IDX_W-1:0]   rd_addr, wr_addr;
  hbwd_pkg::entry_t   rd_data, wr_data;
  hbwd_pkg::res_t     res;

  hbwd_slot_mem #(.DEPTH(SLOTS), .AW(IDX_W)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  hbwd_seq #(.SLOTS(SLOTS), .IDX_W(IDX_W)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .push      (push),
    .res       (res),
    .out_free  (out_free)
  );

  hbwd_out_stage u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .res    (res),
    .free   (out_free),
    .out_ch (out_ch)
  );

endmodule
